// ===== rtl/pidp_pkg.sv =====
`timescale 1ns / 1ps

package pidp_pkg;

  localparam int unsigned GainW    = 32;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned TickW    = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned DriveW   = 22;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [DriveW-1:0]  OutMax      = 22'd2560000;
  localparam logic [DriveW-1:0]  OutMin      = 22'd0;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP     = 2'd0,
    REG_KI     = 2'd1,
    REG_KD     = 2'd2,
    REG_PERIOD = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TickW-1:0]        tick_ms;
    logic signed [DataW-1:0] setpoint;
    logic signed [DataW-1:0] measurement;
  } in_t;

  typedef struct packed {
    logic [DriveW-1:0] drive;
    logic              stepped;
  } out_t;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
    logic [PeriodW-1:0]      period_ms;
  } cfg_t;

  // Read a wrapped 32-bit sum as signed and clamp it to the drive range.
  function automatic logic [DriveW-1:0] clamp_out(input logic [DataW-1:0] v);
    logic [DriveW-1:0] r;
    if (v[DataW-1]) begin
      r = OutMin;
    end else if (v > {{(DataW-DriveW){1'b0}}, OutMax}) begin
      r = OutMax;
    end else begin
      r = v[DriveW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pidp_cfg_regs.sv =====
`timescale 1ns / 1ps

module pidp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pidp_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [pidp_pkg::CfgDataW-1:0]   cfg_wdata,
  output pidp_pkg::cfg_t                  cfg
);

  pidp_pkg::cfg_t cfg_r;
  pidp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (pidp_pkg::reg_idx_t'(cfg_index))
        pidp_pkg::REG_KP:     cfg_nxt.kp        = cfg_wdata;
        pidp_pkg::REG_KI:     cfg_nxt.ki        = cfg_wdata;
        pidp_pkg::REG_KD:     cfg_nxt.kd        = cfg_wdata;
        pidp_pkg::REG_PERIOD: cfg_nxt.period_ms = cfg_wdata[pidp_pkg::PeriodW-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp        <= '0;
      cfg_r.ki        <= '0;
      cfg_r.kd        <= '0;
      cfg_r.period_ms <= pidp_pkg::PeriodReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/pidp_step.sv =====
`timescale 1ns / 1ps

module pidp_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  pidp_pkg::cfg_t  cfg,
  input  pidp_pkg::in_t   item,
  output pidp_pkg::out_t  result
);

  logic [pidp_pkg::PeriodW-1:0] elapsed_r;
  logic [pidp_pkg::PeriodW-1:0] elapsed_nxt;
  logic [pidp_pkg::DataW-1:0]   prev_err_r;
  logic [pidp_pkg::DataW-1:0]   prev_err_nxt;
  logic [pidp_pkg::DriveW-1:0]  integ_r;
  logic [pidp_pkg::DriveW-1:0]  integ_nxt;
  logic [pidp_pkg::DriveW-1:0]  held_r;
  logic [pidp_pkg::DriveW-1:0]  held_nxt;

  logic [pidp_pkg::PeriodW:0]   sum;
  logic [pidp_pkg::PeriodW-1:0] rem;
  logic                         step;
  logic [pidp_pkg::DataW-1:0]   err;
  logic [pidp_pkg::DataW-1:0]   delta;
  logic [pidp_pkg::DataW-1:0]   p_term;
  logic [pidp_pkg::DataW-1:0]   i_term;
  logic [pidp_pkg::DataW-1:0]   d_term;
  logic [pidp_pkg::DataW-1:0]   integ_sum;
  logic [pidp_pkg::DriveW-1:0]  integ_clamped;
  logic [pidp_pkg::DataW-1:0]   out_sum;

  always_comb begin
    // Compare at one bit above the counter so a carry still counts.
    sum  = {1'b0, elapsed_r}
         + {{(pidp_pkg::PeriodW+1-pidp_pkg::TickW){1'b0}}, item.tick_ms};
    rem  = sum[pidp_pkg::PeriodW-1:0] - cfg.period_ms;
    step = (sum >= {1'b0, cfg.period_ms});

    err    = unsigned'(item.setpoint) - unsigned'(item.measurement);
    delta  = err - prev_err_r;
    p_term = pidp_pkg::DataW'(err * unsigned'(cfg.kp));
    i_term = pidp_pkg::DataW'(err * unsigned'(cfg.ki));
    d_term = pidp_pkg::DataW'(delta * unsigned'(cfg.kd));

    integ_sum     = {{(pidp_pkg::DataW-pidp_pkg::DriveW){1'b0}}, integ_r} + i_term;
    integ_clamped = pidp_pkg::clamp_out(integ_sum);
    out_sum       = p_term
                  + {{(pidp_pkg::DataW-pidp_pkg::DriveW){1'b0}}, integ_clamped}
                  + d_term;

    elapsed_nxt  = step ? rem : sum[pidp_pkg::PeriodW-1:0];
    prev_err_nxt = step ? err : prev_err_r;
    integ_nxt    = step ? integ_clamped : integ_r;
    held_nxt     = step ? pidp_pkg::clamp_out(out_sum) : held_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r  <= '0;
      prev_err_r <= '0;
      integ_r    <= '0;
      held_r     <= '0;
    end else if (en) begin
      elapsed_r  <= elapsed_nxt;
      prev_err_r <= prev_err_nxt;
      integ_r    <= integ_nxt;
      held_r     <= held_nxt;
    end
  end

  assign result.drive   = held_nxt;
  assign result.stepped = step;

endmodule

// ===== rtl/pid_controller_periodic_core.sv =====
`timescale 1ns / 1ps
// Path: out_valid rises once the accepted input beat moves from the input register
//   to the result register; while the result register stalls, the beat waits in in_r.
// Throughput: one tick per cycle while out_stall is low; the three 32x32 multiplies,
//   integrator add and two clamps sit in one stage after the input register.
// Reset (rst_n, synchronous, active low): both stages empty, counter, integrator,
//   previous error and held drive cleared, gains zero, period back to 100 ms.

module pid_controller_periodic_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pidp_pkg::in_t                   in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output pidp_pkg::out_t                  out_data,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [pidp_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [pidp_pkg::CfgDataW-1:0]   cfg_wdata
);

  pidp_pkg::cfg_t cfg;
  pidp_pkg::in_t  in_r;
  logic           in_v_r;
  pidp_pkg::out_t out_r;
  logic           out_v_r;
  pidp_pkg::out_t result;
  logic           advance;
  logic           load;

  // Advance the whole pipe whenever the result register is free or drains now.
  assign advance = !out_v_r || !out_stall;
  // Take a new beat into the input register if it is empty or moves on this edge.
  assign load    = !in_v_r || advance;
  assign in_stall = !load;

  pidp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Controller state updates only when its tick leaves for the result register.
  pidp_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance && in_v_r),
    .cfg    (cfg),
    .item   (in_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (load) begin
      in_v_r <= in_valid;
    end
  end

  // Payload registers: hold unless a new beat lands.
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_v_r) begin
      out_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/pidp_checker.sv =====
`timescale 1ns / 1ps

module pidp_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  pidp_pkg::in_t   in_data,
  input  logic            out_valid,
  input  logic            out_stall,
  input  pidp_pkg::out_t  out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Drive never leaves the clamp range.
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.drive <= pidp_pkg::OutMax)
    else $error("drive above clamp limit");

  // Input backpressure only when the result side is full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

  // An offered tick beat carries a known payload.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_data))
    else $error("tick beat offered with unknown payload");

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

endmodule

bind pid_controller_periodic_core pidp_checker u_pidp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
